// ===== sv/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and constants shared by the cache lookup unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int CMD_W   = 2;
   localparam int ADDR_W  = 32;
   localparam int LAT_W   = 10;
   localparam int TAG_W   = 30;
   localparam int CNT_W   = 32;
   localparam int RANK_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LOG2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_LOG2   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_LOG2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WMODE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_CYC    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_CYC   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_THRU_CYC   = 3'd7;

   localparam logic [1:0] WMODE_WT_NOALLOC = 2'd0;
   localparam logic [1:0] WMODE_WB_ALLOC   = 2'd2;

   localparam logic [RANK_W-1:0] RANK_MAX = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   // one way of a set
   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  count;
      logic [RANK_W-1:0] rank;
   } way_type;

   // controls for the way update logic
   typedef struct packed {
      logic is_write;
      logic wb;
      logic lfu;
   } ctl_type;

endpackage

// ===== sv/sacl_req_if.sv =====
// ----------------------------------------------------------------------------
// sacl_req_if
// Request channel: command and byte address.
// ----------------------------------------------------------------------------
interface sacl_req_if;
   import sacl_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, output cmd, output addr, input ready);
   modport sink   (input valid, input cmd, input addr, output ready);
endinterface

// ===== sv/sacl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sacl_rsp_if
// Response channel: hit flag and reported latency.
// ----------------------------------------------------------------------------
interface sacl_rsp_if;
   import sacl_pkg::*;
   logic             valid;
   logic             ready;
   logic             hit;
   logic [LAT_W-1:0] latency;

   modport source (output valid, output hit, output latency, input ready);
   modport sink   (input valid, input hit, input latency, output ready);
endinterface

// ===== sv/sacl_tag_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_tag_ram
// Set memory, one row per set, with a per-row valid bit so that flush and
// reset clear the whole store at once. Unwritten rows read as zero.
// ----------------------------------------------------------------------------
module sacl_tag_ram
   import sacl_pkg::*;
#(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 16,
   parameter int SET_W    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   rd_en,
   input  logic [SET_W-1:0]       rd_addr,
   output way_type [MAX_WAYS-1:0] rd_data,
   input  logic                   wr_en,
   input  logic [SET_W-1:0]       wr_addr,
   input  way_type [MAX_WAYS-1:0] wr_data
);

   way_type [MAX_WAYS-1:0] mem [MAX_SETS];
   logic [MAX_SETS-1:0]    row_vld_ff;
   logic                   rd_vld_ff;
   way_type [MAX_WAYS-1:0] rd_data_ff;

   // write the row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // track written rows
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= row_vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== sv/sacl_way_sel.sv =====
// ----------------------------------------------------------------------------
// sacl_way_sel
// Tag compare, fill/victim choice and row update for one set.
// ----------------------------------------------------------------------------
module sacl_way_sel
   import sacl_pkg::*;
#(
   parameter int MAX_WAYS = 16,
   parameter int WL_W     = 3
) (
   input  way_type [MAX_WAYS-1:0] row_in,
   input  logic [TAG_W-1:0]       tag,
   input  logic [WL_W-1:0]        ways_log2,
   input  ctl_type                ctl,
   output logic                   hit,
   output way_type [MAX_WAYS-1:0] row_out
);

   localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int POW    = 2 ** WIDX_W;

   logic [MAX_WAYS-1:0] in_use, match, invalid;
   logic [WIDX_W-1:0]   hit_way, fill_way, sel_way;
   logic                fill_any, evict;
   logic [WIDX_W-1:0]   t_idx  [POW];
   logic                t_use  [POW];
   logic [CNT_W-1:0]    t_cnt  [POW];
   logic [RANK_W-1:0]   t_rank [POW];
   logic [RANK_W-1:0]   sel_rank;
   logic                take_b;

   // find hit and first invalid way among ways in use
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i]  = ((32'(i) >> ways_log2) == 32'd0);
         match[i]   = in_use[i] && row_in[i].valid && (row_in[i].tag == tag);
         invalid[i] = in_use[i] && !row_in[i].valid;
      end
      hit_way  = '0;
      fill_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = WIDX_W'(i);
         end
         if (invalid[i]) begin
            fill_way = WIDX_W'(i);
         end
      end
      hit      = |match;
      fill_any = |invalid;
   end

   // victim tree: LFU takes the later way on ties, LRU the earlier one
   always_comb begin
      take_b = 1'b0;
      for (int i = 0; i < POW; i++) begin
         t_idx[i] = WIDX_W'(i);
         if (i < MAX_WAYS) begin
            t_use[i]  = in_use[i];
            t_cnt[i]  = row_in[i].count;
            t_rank[i] = row_in[i].rank;
         end else begin
            t_use[i]  = 1'b0;
            t_cnt[i]  = '0;
            t_rank[i] = '0;
         end
      end
      for (int s = 1; s < POW; s = s * 2) begin
         for (int i = 0; i + s < POW; i = i + 2 * s) begin
            take_b = t_use[i+s] && (ctl.lfu ? (t_cnt[i+s] <= t_cnt[i])
                                            : (t_rank[i+s] > t_rank[i]));
            if (take_b) begin
               t_idx[i]  = t_idx[i+s];
               t_cnt[i]  = t_cnt[i+s];
               t_rank[i] = t_rank[i+s];
            end
         end
      end
   end

   assign evict   = !hit && !fill_any;
   assign sel_way = hit ? hit_way : (fill_any ? fill_way : t_idx[0]);
   assign sel_rank = row_in[sel_way].rank;

   // build the updated row
   always_comb begin
      row_out = row_in;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WIDX_W'(i) == sel_way) begin
            if (!hit) begin
               row_out[i].valid = 1'b1;
               row_out[i].tag   = tag;
               row_out[i].dirty = ctl.is_write && ctl.wb;
               if (evict) begin
                  row_out[i].count = '0;
               end
            end else if (ctl.is_write && ctl.wb) begin
               row_out[i].dirty = 1'b1;
            end
            if (ctl.lfu) begin
               if (row_out[i].count != CNT_MAX) begin
                  row_out[i].count = row_out[i].count + 1'b1;
               end
            end else begin
               row_out[i].rank = '0;
            end
         end else if (in_use[i] && !ctl.lfu) begin
            // age ways younger than the touched one, all on a miss
            if ((!hit || (row_in[i].rank < sel_rank)) && (row_in[i].rank != RANK_MAX)) begin
               row_out[i].rank = row_in[i].rank + 1'b1;
            end
         end
      end
   end

endmodule

// ===== sv/set_assoc_cache_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_unit
// Set-associative tag store with LRU or LFU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a command (read, write, flush) and a byte address;
//   rsp channel returns one word per request: hit flag and write latency.
//   csr port writes geometry, policy, write mode and latencies; write it
//   only while no request is in flight.
// Timing:
//   Reads and allocating writes read the set row from the set memory in the
//   accept cycle, then compare, update and write it back in the next; no new
//   request is taken until that row has been written back.
//   Flush, unused commands and no-allocate writes skip the set memory; flush
//   clears per-row valid bits at once, so no clearing pass is needed.
// Reset:
//   All sets read as empty; state, response valid and configuration registers take their default values.
// Stall:
//   The response sits in an output register; a new request is taken while
//   that register drains, and none while a response waits untaken.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_unit
   import sacl_pkg::*;
#(
   parameter int MAX_SETS  = 256,
   parameter int MAX_WAYS  = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   sacl_req_if.sink              req_ch,
   sacl_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SL_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int WL_MAX = $clog2(MAX_WAYS + 1) - 1;
   localparam int WL_W   = 3;
   localparam logic [32:0] AMASK = (33'd1 << ADDR_BITS) - 33'd1;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOOK = 1'b1;

   // configuration registers
   logic [3:0]       bs_cfg_ff, sl_cfg_ff;
   logic [2:0]       wl_cfg_ff;
   logic             policy_ff;
   logic [1:0]       wmode_ff;
   logic [LAT_W-1:0] hit_cyc_ff, miss_cyc_ff, thru_cyc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_cfg_ff   <= 4'd6;
         sl_cfg_ff   <= 4'd8;
         wl_cfg_ff   <= 3'd2;
         policy_ff   <= 1'b0;
         wmode_ff    <= 2'd2;
         hit_cyc_ff  <= 10'd1;
         miss_cyc_ff <= 10'd100;
         thru_cyc_ff <= 10'd100;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_LOG2: bs_cfg_ff   <= csr_wdata[3:0];
            CSR_SET_LOG2:   sl_cfg_ff   <= csr_wdata[3:0];
            CSR_WAYS_LOG2:  wl_cfg_ff   <= csr_wdata[2:0];
            CSR_POLICY:     policy_ff   <= csr_wdata[0];
            CSR_WMODE:      wmode_ff    <= csr_wdata[1:0];
            CSR_HIT_CYC:    hit_cyc_ff  <= csr_wdata;
            CSR_MISS_CYC:   miss_cyc_ff <= csr_wdata;
            CSR_THRU_CYC:   thru_cyc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp geometry
   logic [3:0]        bs, sl;
   logic [WL_W-1:0]   wl;
   logic [4:0]        tag_shift;
   logic [ADDR_W-1:0] addr_m, set_mask, set_full, tag_full;

   always_comb begin
      bs = (bs_cfg_ff < 4'd2) ? 4'd2 : ((bs_cfg_ff > 4'd9) ? 4'd9 : bs_cfg_ff);
      sl = (sl_cfg_ff > 4'(SL_MAX)) ? 4'(SL_MAX) : sl_cfg_ff;
      wl = (wl_cfg_ff > 3'(WL_MAX)) ? 3'(WL_MAX) : wl_cfg_ff;
      tag_shift = {1'b0, bs} + {1'b0, sl};
      addr_m    = req_ch.addr & AMASK[ADDR_W-1:0];
      set_mask  = (32'd1 << sl) - 32'd1;
      set_full  = (addr_m >> bs) & set_mask;
      tag_full  = addr_m >> tag_shift;
   end

   // control
   logic             state_ff, state_in;
   logic             accept, needs_look;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [LAT_W-1:0] rsp_lat_ff, rsp_lat_in;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             is_write_ff;
   ctl_type          ctl;
   logic             look_hit;
   way_type [MAX_WAYS-1:0] row_rd, row_wr;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign needs_look   = (req_ch.cmd == CMD_READ) ||
                         ((req_ch.cmd == CMD_WRITE) && (wmode_ff != WMODE_WT_NOALLOC));

   assign ctl.is_write = is_write_ff;
   assign ctl.wb       = (wmode_ff >= WMODE_WB_ALLOC);
   assign ctl.lfu      = policy_ff;

   // next state and response word
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_lat_in   = rsp_lat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (needs_look) begin
                  state_in = S_LOOK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_lat_in   = ((req_ch.cmd == CMD_WRITE) ? thru_cyc_ff : '0);
               end
            end
         end
         S_LOOK: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = look_hit;
            if (!is_write_ff) begin
               rsp_lat_in = '0;
            end else if (!look_hit) begin
               rsp_lat_in = miss_cyc_ff;
            end else begin
               rsp_lat_in = ctl.wb ? hit_cyc_ff : thru_cyc_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload of the response and of the access in flight
   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_lat_ff <= rsp_lat_in;
      if (accept) begin
         set_ff      <= set_full[SET_W-1:0];
         tag_ff      <= tag_full[TAG_W-1:0];
         is_write_ff <= (req_ch.cmd == CMD_WRITE);
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.hit     = rsp_hit_ff;
   assign rsp_ch.latency = rsp_lat_ff;

   sacl_tag_ram #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS),
      .SET_W    (SET_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept && (req_ch.cmd == CMD_FLUSH)),
      .rd_en   (accept && needs_look),
      .rd_addr (set_full[SET_W-1:0]),
      .rd_data (row_rd),
      .wr_en   (state_ff == S_LOOK),
      .wr_addr (set_ff),
      .wr_data (row_wr)
   );

   sacl_way_sel #(
      .MAX_WAYS (MAX_WAYS),
      .WL_W     (WL_W)
   ) u_sel (
      .row_in    (row_rd),
      .tag       (tag_ff),
      .ways_log2 (wl),
      .ctl       (ctl),
      .hit       (look_hit),
      .row_out   (row_wr)
   );

endmodule
